>>> rtl/sac_pkg.sv
// ----------------------------------------------------------------------------
// sac_pkg
// shared types and codes of the set-associative tag array
// ----------------------------------------------------------------------------
package sac_pkg;

  typedef enum logic [3:0] {
    REQ_ACCESS   = 4'd0,
    REQ_TEST     = 4'd1,
    REQ_PRESENT  = 4'd2,
    REQ_AVAIL    = 4'd3,
    REQ_ALLOC    = 4'd4,
    REQ_DEALLOC  = 4'd5,
    REQ_PROBE    = 4'd6,
    REQ_MRU      = 4'd7,
    REQ_SETPERM  = 4'd8,
    REQ_LOCK     = 4'd9,
    REQ_UNLOCK   = 4'd10,
    REQ_ISLOCKED = 4'd11
  } req_e;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ALIGN = 2'd1;
  localparam logic [1:0] ST_PRE   = 2'd2;

  localparam logic [1:0] PERM_NP  = 2'd0;
  localparam logic [1:0] PERM_INV = 2'd1;
  localparam logic [1:0] PERM_RO  = 2'd2;
  localparam logic [1:0] PERM_RW  = 2'd3;

  localparam logic [1:0] KIND_FETCH = 2'd1;

  localparam logic CFG_OFFSET = 1'b0;
  localparam logic CFG_INDEX  = 1'b1;

  // one-hot sequencer states
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CLEAR = 4'b0010,
    S_READ  = 4'b0100,
    S_OUT   = 4'b1000
  } state_e;

endpackage

>>> rtl/sac_ram.sv
// ----------------------------------------------------------------------------
// sac_ram
// generic single-port synchronous ram with registered read
// ----------------------------------------------------------------------------
module sac_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // read returns the old word during a write, read data registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

>>> rtl/set_assoc_cache_tag_array_core.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_array_core
// set-associative tag array with strict lru replacement and line locks
// ----------------------------------------------------------------------------
// channel      dir  handshake                 payload
// s_axis       in   s_axis_tvalid/tready      tdata: req, address, kind, perm, ctx
// m_axis       out  m_axis_tvalid/tready      tdata: status, answer, way, perm, victim
// cfg          in   cfg_valid_i/cfg_ready_o   cfg_index_i, cfg_data_i
//
// one request goes through three steps: accept, one set row read, then
// compare, update and write back together in the output state; the single row
// port sets this. after reset a clearing pass writes every row; no request
// is accepted meanwhile. a result waits in its output register while
// the next request is accepted and read; the write back stalls until it leaves.
module set_assoc_cache_tag_array_core #(
  parameter int SETS          = 256,
  parameter int WAYS          = 8,
  parameter int ADDR_BITS     = 48,
  parameter int LOCK_CONTEXTS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // req_type[3:0], line_addr[51:4], access_kind[53:52],
  // new_permission[55:54], lock_context[63:56]
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], answer[2], hit_way[5:3], line_permission[7:6],
  // victim_address[55:8]
  output logic [55:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [4:0]  cfg_data_i
);
  import sac_pkg::*;

  localparam int IdxW  = $clog2(SETS) > 0 ? $clog2(SETS) : 1;
  localparam int SetBits = $clog2(SETS + 1) - 1;
  localparam int WayW  = $clog2(WAYS) > 0 ? $clog2(WAYS) : 1;
  localparam int EntW  = 1 + 48 + 2 + 1 + 8 + WayW;
  localparam int RowW  = EntW * WAYS;

  typedef struct packed {
    logic          valid;
    logic [47:0]   tag;
    logic [1:0]    perm;
    logic          held;
    logic [7:0]    owner;
    logic [WayW-1:0] rank;
  } entry_t;

  state_e state_q, state_d;
  logic [3:0] off_q;
  logic [4:0] isb_q;
  logic [IdxW:0] clr_q;
  logic [3:0]  req_q;
  logic [47:0] addr_q;
  logic [1:0]  kind_q, nperm_q;
  logic [7:0]  ctx_q;
  logic        mis_q;
  logic [IdxW-1:0] set_q;
  logic        ov_q;
  logic [55:0] od_q;

  entry_t row_r [WAYS];
  entry_t row_w [WAYS];
  logic [RowW-1:0] rdata, wdata;
  logic        we;
  logic [IdxW-1:0] raddr;

  // config is taken whenever idle
  assign cfg_ready_o = state_q == S_IDLE;
  assign s_axis_tready = state_q == S_IDLE && !cfg_valid_i;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;

  // input field decode
  logic [47:0] in_addr;
  logic [63:0] amask;
  assign amask   = (ADDR_BITS >= 64) ? '1 : ((64'd1 << ADDR_BITS) - 64'd1);
  assign in_addr = s_axis_tdata[51:4] & amask[47:0];

  logic [47:0] sh_addr;
  assign sh_addr = in_addr >> isb_q;
  logic [IdxW-1:0] in_set;
  always_comb begin
    in_set = '0;
    for (int b = 0; b < IdxW; b++) begin
      if (b < SetBits) in_set[b] = sh_addr[b];
    end
  end

  logic [47:0] off_mask;
  assign off_mask = (48'd1 << off_q) - 48'd1;

  assign raddr = (state_q == S_CLEAR) ? clr_q[IdxW-1:0] :
                 (state_q == S_IDLE) ? in_set : set_q;

  sac_ram #(.Width(RowW), .Depth(SETS)) u_ram (
    .clk_i, .we_i(we), .addr_i(raddr), .wdata_i(wdata), .rdata_o(rdata)
  );

  // row unpack and pack
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      row_r[w] = rdata[w*EntW +: EntW];
      wdata[w*EntW +: EntW] = row_w[w];
    end
  end

  // match and free search over the set
  logic hit, has_free, avail, vic_ok;
  logic [WayW-1:0] found, freew, vic, tw;
  logic dotouch;
  always_comb begin
    hit = 1'b0; has_free = 1'b0; avail = 1'b0; vic_ok = 1'b0;
    found = '0; freew = '0; vic = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (!row_r[w].valid || row_r[w].perm == PERM_NP) begin
        has_free = 1'b1; freew = WayW'(w);
      end
      if (row_r[w].valid && row_r[w].tag == addr_q) begin
        avail = 1'b1;
        if (row_r[w].perm != PERM_NP) begin
          hit = 1'b1; found = WayW'(w);
        end
      end
      if (row_r[w].rank == '0) begin
        vic_ok = 1'b1; vic = WayW'(w);
      end
    end
    if (has_free) avail = 1'b1;
  end

  // operation result and row update
  logic [1:0] st, rperm;
  logic ans;
  logic [WayW-1:0] rway;
  logic [47:0] victim;
  entry_t fe;
  always_comb begin
    st = ST_OK; ans = 1'b0; rway = '0; rperm = '0; victim = '0;
    dotouch = 1'b0; tw = found;
    for (int w = 0; w < WAYS; w++) row_w[w] = row_r[w];
    fe = row_r[found];
    if (hit) begin
      rway = found; rperm = fe.perm;
    end
    if (mis_q) begin
      st = ST_ALIGN;
    end else begin
      unique case (req_q)
        REQ_ACCESS: begin
          dotouch = hit;
          ans = hit && (fe.perm == PERM_RW ||
                (fe.perm == PERM_RO && kind_q <= KIND_FETCH));
        end
        REQ_TEST: begin dotouch = hit; ans = hit; end
        REQ_PRESENT: ans = hit;
        REQ_AVAIL: ans = avail;
        REQ_ALLOC: begin
          if (hit || !has_free) st = ST_PRE;
          else begin
            row_w[freew].valid = 1'b1;
            row_w[freew].tag = addr_q;
            row_w[freew].perm = PERM_INV;
            row_w[freew].held = 1'b0;
            dotouch = 1'b1; tw = freew;
            ans = 1'b1; rway = freew; rperm = PERM_INV;
          end
        end
        REQ_DEALLOC: begin
          if (!hit) st = ST_PRE;
          else begin
            row_w[found].valid = 1'b0; row_w[found].held = 1'b0;
          end
        end
        REQ_PROBE: begin
          if (avail) st = ST_PRE;
          else begin
            rway = vic_ok ? vic : '0;
            rperm = row_r[rway].perm;
            victim = row_r[rway].tag;
          end
        end
        REQ_MRU: dotouch = hit;
        REQ_SETPERM: begin
          if (!hit) st = ST_PRE;
          else row_w[found].perm = nperm_q;
        end
        REQ_LOCK: begin
          if (!hit || 32'(ctx_q) >= LOCK_CONTEXTS) st = ST_PRE;
          else begin
            row_w[found].held = 1'b1; row_w[found].owner = ctx_q;
          end
        end
        REQ_UNLOCK: begin
          if (!hit) st = ST_PRE;
          else row_w[found].held = 1'b0;
        end
        REQ_ISLOCKED: begin
          if (!hit || 32'(ctx_q) >= LOCK_CONTEXTS) st = ST_PRE;
          else ans = fe.held && fe.owner == ctx_q;
        end
        default: st = ST_PRE;
      endcase
    end
    // lru touch: ranks above the touched way drop by one
    if (dotouch && st == ST_OK) begin
      for (int w = 0; w < WAYS; w++) begin
        if (row_r[w].rank > row_r[tw].rank) row_w[w].rank = row_r[w].rank - 1'b1;
      end
      row_w[tw].rank = WayW'(WAYS - 1);
    end
    if (st != ST_OK) begin
      ans = 1'b0; rway = '0; rperm = '0; victim = '0;
      for (int w = 0; w < WAYS; w++) row_w[w] = row_r[w];
    end
    // clearing pass writes the reset row
    if (state_q == S_CLEAR) begin
      for (int w = 0; w < WAYS; w++) begin
        row_w[w] = '0;
        row_w[w].rank = WayW'(w);
      end
    end
  end

  logic out_free;
  assign out_free = !ov_q || m_axis_tready;
  assign we = (state_q == S_CLEAR) || (state_q == S_OUT && out_free);

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (s_axis_tvalid && s_axis_tready) state_d = S_READ;
      S_CLEAR: if (clr_q == (IdxW+1)'(SETS - 1)) state_d = S_IDLE;
      S_READ:  state_d = S_OUT;
      S_OUT:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  logic [2:0] way3;
  assign way3 = 3'(rway);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      off_q   <= 4'd6;
      isb_q   <= 5'd6;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_OFFSET) off_q <= cfg_data_i[3:0];
        else isb_q <= cfg_data_i;
      end
      if (state_q == S_OUT && out_free) ov_q <= 1'b1;
      else if (m_axis_tready) ov_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req_q   <= s_axis_tdata[3:0];
      addr_q  <= in_addr;
      kind_q  <= s_axis_tdata[53:52];
      nperm_q <= s_axis_tdata[55:54];
      ctx_q   <= s_axis_tdata[63:56];
      mis_q   <= (s_axis_tdata[51:4] & off_mask) != '0;
      set_q   <= in_set;
    end
    if (state_q == S_OUT && out_free) begin
      od_q <= {victim, rperm, way3, ans, st};
    end
  end

`ifndef ASSERT_OFF
  a_one_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> state_q == S_IDLE) else $error("accept while busy");
  a_read_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |=> state_q == S_OUT) else $error("read not followed");
  a_write_only_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == S_OUT || state_q == S_CLEAR)) else $error("stray write");
`endif

endmodule

>>> tb/set_assoc_cache_tag_array_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_array_core_tb
// streams lookup, allocate, permission and lock requests into the tag array
// under random gaps and back-pressure, tracks the sets and lru order in a
// mirror of the array, and checks every response field by field
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_array_core_tb;
  import sac_pkg::*;

  localparam int SETS      = 256;
  localparam int WAYS      = 8;
  localparam int SET_BITS  = 8;
  localparam int LOCK_CONTEXTS = 256;
  localparam int MAX_CYC   = 600000;
  localparam logic [3:0] REQ_BAD = 4'd15;

  typedef struct packed {
    logic [7:0]  ctx;
    logic [1:0]  perm;
    logic [1:0]  kind;
    logic [47:0] addr;
    logic [3:0]  req;
  } req_t;

  typedef struct packed {
    logic [47:0] victim;
    logic [1:0]  perm;
    logic [2:0]  way;
    logic        answer;
    logic [1:0]  status;
  } rsp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i = '0;
  logic [4:0]  cfg_data_i = '0;

  set_assoc_cache_tag_array_core i_dut (.*);

  always #6 clk_i = ~clk_i;

  // mirror of the array and its configuration
  logic        line_vld   [SETS*WAYS];
  logic [47:0] line_tag   [SETS*WAYS];
  logic [1:0]  line_perm  [SETS*WAYS];
  logic        lock_vld   [SETS*WAYS];
  logic [7:0]  lock_ctx   [SETS*WAYS];
  logic [2:0]  lru_pos    [SETS*WAYS];
  logic [3:0]  offs_cfg;
  logic [4:0]  idx_cfg;

  req_t  pending_reqs[$];
  rsp_t  resp_expected[$];
  int    err_cnt = 0;
  int    rsp_cnt = 0;
  int    cyc = 0;
  int    gap_left = 0;
  logic [47:0] addr_pool[36];

  function automatic void make_mru(int base, int way);
    logic [2:0] r;
    r = lru_pos[base+way];
    for (int w = 0; w < WAYS; w++)
      if (lru_pos[base+w] > r) lru_pos[base+w] = lru_pos[base+w] - 3'd1;
    lru_pos[base+way] = 3'(WAYS - 1);
  endfunction

  // compute the response of one request and update the mirror
  function automatic rsp_t tag_lookup_predict(req_t q);
    rsp_t  o;
    int    base, found, freew, v;
    bit    hit, has_free, avail;
    logic [47:0] lowmask;
    o = '0; hit = 0; has_free = 0; avail = 0; found = 0; freew = 0; v = 0;
    lowmask = (48'd1 << offs_cfg) - 48'd1;
    if ((q.addr & lowmask) != 0) begin
      o.status = ST_ALIGN;
      return o;
    end
    base = int'((q.addr >> idx_cfg) & 48'(SETS - 1)) * WAYS;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (!line_vld[base+w] || line_perm[base+w] == PERM_NP) begin
        has_free = 1; freew = w;
      end
      if (line_vld[base+w] && line_tag[base+w] == q.addr) begin
        avail = 1;
        if (line_perm[base+w] != PERM_NP) begin
          hit = 1; found = w;
        end
      end
    end
    if (has_free) avail = 1;
    if (hit) begin
      o.way = 3'(found);
      o.perm = line_perm[base+found];
    end
    case (q.req)
      REQ_ACCESS: if (hit) begin
        make_mru(base, found);
        o.answer = (o.perm == PERM_RW) || (o.perm == PERM_RO && q.kind <= KIND_FETCH);
      end
      REQ_TEST: if (hit) begin
        make_mru(base, found);
        o.answer = 1'b1;
      end
      REQ_PRESENT: o.answer = hit;
      REQ_AVAIL:   o.answer = avail;
      REQ_ALLOC: if (hit || !has_free) o.status = ST_PRE;
      else begin
        line_vld[base+freew] = 1'b1;
        line_tag[base+freew] = q.addr;
        line_perm[base+freew] = PERM_INV;
        lock_vld[base+freew] = 1'b0;
        make_mru(base, freew);
        o.answer = 1'b1; o.way = 3'(freew); o.perm = PERM_INV;
      end
      REQ_DEALLOC: if (!hit) o.status = ST_PRE;
      else begin
        line_vld[base+found] = 1'b0;
        lock_vld[base+found] = 1'b0;
      end
      REQ_PROBE: if (avail) o.status = ST_PRE;
      else begin
        for (int w = WAYS - 1; w >= 0; w--)
          if (lru_pos[base+w] == 0) v = w;
        o.way = 3'(v);
        o.perm = line_perm[base+v];
        o.victim = line_tag[base+v];
      end
      REQ_MRU: if (hit) make_mru(base, found);
      REQ_SETPERM: if (!hit) o.status = ST_PRE;
      else line_perm[base+found] = q.perm;
      REQ_LOCK: if (!hit || int'(q.ctx) >= LOCK_CONTEXTS) o.status = ST_PRE;
      else begin
        lock_vld[base+found] = 1'b1;
        lock_ctx[base+found] = q.ctx;
      end
      REQ_UNLOCK: if (!hit) o.status = ST_PRE;
      else lock_vld[base+found] = 1'b0;
      REQ_ISLOCKED: if (!hit || int'(q.ctx) >= LOCK_CONTEXTS) o.status = ST_PRE;
      else o.answer = lock_vld[base+found] && lock_ctx[base+found] == q.ctx;
      default: o.status = ST_PRE;
    endcase
    if (o.status != ST_OK) o = '{default: '0, status: o.status};
    return o;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (cyc[9:8] == 2'd0 || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [47:0] aligned(logic [47:0] a);
    return a & ~((48'd1 << offs_cfg) - 48'd1);
  endfunction

  function automatic logic [47:0] line_at(int set, logic [47:0] tag);
    return aligned((tag << (idx_cfg + SET_BITS)) | (48'(set) << idx_cfg));
  endfunction

  function automatic req_t mk(req_e r, logic [47:0] a, logic [1:0] k = 2'd0,
                              logic [1:0] p = PERM_NP, logic [7:0] c = 8'd0);
    return '{ctx: c, perm: p, kind: k, addr: a, req: r};
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!(s_axis_tvalid && !s_axis_tready)) begin
      if (s_axis_tvalid) void'(pending_reqs.pop_front());
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        s_axis_tdata <= pending_reqs[0];
        s_axis_tvalid <= 1'b1;
        gap_left <= pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // response back-pressure, with one long hold-off
  int  stall_left = 0;
  bit  held = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!held && rsp_cnt >= 120) begin
      held <= 1;
      stall_left <= 300;
      m_axis_tready <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      stall_left <= pick_gap();
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // monitor: predict on accepted requests, check accepted responses
  always @(posedge clk_i) begin
    rsp_t got, want;
    cyc <= cyc + 1;
    if (s_axis_tvalid && s_axis_tready)
      resp_expected.push_back(tag_lookup_predict(s_axis_tdata));
    if (m_axis_tvalid && m_axis_tready) begin
      rsp_cnt <= rsp_cnt + 1;
      got = m_axis_tdata;
      if (resp_expected.size() == 0) begin
        $error("response with no request outstanding: %h", m_axis_tdata);
        err_cnt++;
      end else begin
        want = resp_expected.pop_front();
        if (got.status != want.status) begin
          $error("status exp %0d got %0d", want.status, got.status); err_cnt++;
        end
        if (got.answer != want.answer) begin
          $error("answer exp %0d got %0d", want.answer, got.answer); err_cnt++;
        end
        if (got.way != want.way) begin
          $error("hit_way exp %0d got %0d", want.way, got.way); err_cnt++;
        end
        if (got.perm != want.perm) begin
          $error("line_permission exp %0d got %0d", want.perm, got.perm); err_cnt++;
        end
        if (got.victim != want.victim) begin
          $error("victim_address exp %h got %h", want.victim, got.victim);
          err_cnt++;
        end
      end
    end
    if (cyc > MAX_CYC) begin
      $display("set_assoc_cache_tag_array_core_tb: done, errors");
      $finish;
    end
  end

  task automatic write_reg(logic [0:0] idx, logic [4:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_OFFSET) offs_cfg = val[3:0];
    else idx_cfg = val;
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (pending_reqs.size() != 0 || resp_expected.size() != 0 || s_axis_tvalid);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic random_requests(int n);
    int    r, s;
    req_t  q;
    for (int i = 0; i < 36; i++) begin
      s = (i < 12) ? 0 : (i < 24) ? SETS - 1 : 0;
      if (i == 24) s = $urandom_range(1, SETS - 2);
      addr_pool[i] = line_at(i <= 24 ? s : int'((addr_pool[24] >> idx_cfg) & 48'(SETS - 1)),
                             48'({$urandom, $urandom} %
                                 ((i % 12 == 0) ? 48'hFFFF_FFFF_FFFF : 48'd64)));
    end
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      q.ctx  = 8'($urandom);
      q.perm = 2'($urandom);
      q.kind = 2'($urandom);
      q.req  = r < 22 ? REQ_ALLOC : r < 35 ? REQ_ACCESS : r < 42 ? REQ_TEST :
               r < 48 ? REQ_PRESENT : r < 53 ? REQ_AVAIL : r < 60 ? REQ_DEALLOC :
               r < 67 ? REQ_PROBE : r < 72 ? REQ_MRU : r < 80 ? REQ_SETPERM :
               r < 86 ? REQ_LOCK : r < 90 ? REQ_UNLOCK : r < 96 ? REQ_ISLOCKED :
               4'($urandom_range(12, 15));
      // setting lines free too often keeps sets from filling
      if (q.req == REQ_SETPERM && q.perm == PERM_NP && $urandom_range(0, 2) != 0)
        q.perm = PERM_RW;
      r = $urandom_range(0, 99);
      if (r < 85) q.addr = addr_pool[$urandom_range(0, 35)];
      else if (r < 93) q.addr = aligned(48'({$urandom, $urandom}));
      else q.addr = 48'({$urandom, $urandom});
      pending_reqs.push_back(q);
    end
  endtask

  initial begin
    logic [47:0] a, c;
    for (int i = 0; i < SETS*WAYS; i++) begin
      line_vld[i] = 1'b0; lock_vld[i] = 1'b0; line_tag[i] = '0;
      line_perm[i] = PERM_NP; lock_ctx[i] = '0; lru_pos[i] = 3'(i % WAYS);
    end
    offs_cfg = 4'd6;
    idx_cfg  = 5'd6;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: corner fields, every operation, misuse cases
    a = line_at(5, 48'h3_FFFF_FFFF);
    c = line_at(5, 48'h77);
    pending_reqs.push_back(mk(REQ_ACCESS, a | 48'd1));
    pending_reqs.push_back(mk(req_e'(REQ_BAD), a));
    pending_reqs.push_back(mk(REQ_PRESENT, 48'hFFFF_FFFF_FFC0));
    pending_reqs.push_back(mk(REQ_DEALLOC, a));
    pending_reqs.push_back(mk(REQ_ALLOC, a));
    pending_reqs.push_back(mk(REQ_ALLOC, a));
    pending_reqs.push_back(mk(REQ_ACCESS, a, 2'd3));
    pending_reqs.push_back(mk(REQ_SETPERM, a, 2'd0, PERM_RO));
    pending_reqs.push_back(mk(REQ_ACCESS, a, 2'd0));
    pending_reqs.push_back(mk(REQ_ACCESS, a, KIND_FETCH));
    pending_reqs.push_back(mk(REQ_ACCESS, a, 2'd2));
    pending_reqs.push_back(mk(REQ_SETPERM, a, 2'd0, PERM_RW));
    pending_reqs.push_back(mk(REQ_ACCESS, a, 2'd3));
    pending_reqs.push_back(mk(REQ_LOCK, a, 2'd0, PERM_NP, 8'd255));
    pending_reqs.push_back(mk(REQ_ISLOCKED, a, 2'd0, PERM_NP, 8'd255));
    pending_reqs.push_back(mk(REQ_ISLOCKED, a, 2'd0, PERM_NP, 8'd0));
    pending_reqs.push_back(mk(REQ_UNLOCK, a));
    pending_reqs.push_back(mk(REQ_TEST, a));
    pending_reqs.push_back(mk(REQ_MRU, a));
    pending_reqs.push_back(mk(REQ_PROBE, c));
    // fill the set, then probe for the lru victim and overflow an allocate
    for (int i = 1; i < WAYS; i++) pending_reqs.push_back(mk(REQ_ALLOC, line_at(5, 48'(i))));
    pending_reqs.push_back(mk(REQ_AVAIL, c));
    pending_reqs.push_back(mk(REQ_PROBE, c));
    pending_reqs.push_back(mk(REQ_ALLOC, c));
    pending_reqs.push_back(mk(REQ_SETPERM, a, 2'd0, PERM_NP));
    pending_reqs.push_back(mk(REQ_AVAIL, a));
    pending_reqs.push_back(mk(REQ_DEALLOC, a));
    random_requests(170);
    drain();

    // line size and index position at low, high and middle settings
    write_reg(CFG_OFFSET, 5'd2);
    write_reg(CFG_INDEX, 5'd2);
    random_requests(170);
    drain();
    write_reg(CFG_OFFSET, 5'd12);
    write_reg(CFG_INDEX, 5'd24);
    random_requests(170);
    drain();
    write_reg(CFG_OFFSET, 5'd4);
    write_reg(CFG_INDEX, 5'd13);
    random_requests(170);
    drain();

    if (err_cnt == 0) begin
      $display("set_assoc_cache_tag_array_core_tb: done, clean");
    end else begin
      $display("set_assoc_cache_tag_array_core_tb: done, errors");
    end
    $finish;
  end

endmodule
